// ----- src/itda_pkg.sv -----
// Shared types and constants for the integer to decimal ASCII unit.
`timescale 1ns / 1ps

package itda_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned BITCNT_W   = $clog2(VALUE_W);
  localparam int unsigned LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_signed;
    logic               is_wide;
  } in_item_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_item_t;

  // Per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic digit_shift;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_TRIM,
    ST_SIGN,
    ST_EMIT
  } state_t;

endpackage

// ----- src/itda_cell.sv -----
// One BCD digit cell of the shift-and-add-3 chain.
`timescale 1ns / 1ps

module itda_cell
  import itda_pkg::*;
(
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  logic               bit_in,
  input  logic [DIGIT_W-1:0] digit_in,
  output logic               bit_out,
  output logic [DIGIT_W-1:0] digit_q
);

  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W-1:0] digit_nxt;
  logic [DIGIT_W-1:0] adj;

  // add 3 before the shift when the digit would overflow past 9
  assign adj     = (digit_r >= DIGIT_W'(5)) ? digit_r + DIGIT_W'(3) : digit_r;
  assign bit_out = adj[DIGIT_W-1];
  assign digit_q = digit_r;

  always_comb begin
    priority if (ctrl.clear) begin
      digit_nxt = '0;
    end else if (ctrl.bit_shift) begin
      digit_nxt = {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.digit_shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ----- src/integer_to_decimal_ascii_unit.sv -----
// Top level: integer to decimal ASCII text, one character per output item.
//
// Input channel in_valid/in_stall/in_item carries a 64-bit value with two
// mode flags (is_signed, is_wide). Narrow mode uses only the low 32 bits.
// Output channel out_valid/out_stall/out_item carries one ASCII character
// per item, most significant digit first, '-' first for a negative value,
// with last set on the final character. Zero gives a single '0'.
// One number is converted at a time. After acceptance, the 64-bit magnitude
// is shifted bit by bit through a chain of 20 BCD digit cells, then the
// trim state drops leading zeros by moving digits toward the top cell
// (its final step only checks the top digit), then one character
// leaves per cycle through the output register unless out_stall holds it.
// in_stall is high from acceptance until the last character has been loaded
// into the output register, so the next item can enter while that character
// still waits.
// While out_stall is high the output item holds and emission pauses.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_unit
  import itda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  mag_r;
  logic                neg_r;
  logic [BITCNT_W-1:0] cnt_r;
  logic [LEFT_W-1:0]   left_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  cell_ctrl_t          ctrl;
  logic                accept;
  logic                can_load;
  logic                top_zero;
  logic [VALUE_W-1:0]  mag_in;
  logic                neg_in;
  logic [31:0]         low;

  logic [NUM_DIGITS:0]               bit_chain;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
  logic [DIGIT_W-1:0]                top_digit;

  assign accept    = in_valid && !in_stall;
  assign can_load  = !out_valid_r || !out_stall;
  assign top_digit = digits[NUM_DIGITS-1];
  assign top_zero  = (top_digit == '0);

  // magnitude at the chosen width, the unsigned negation when the value is negative
  always_comb begin
    low = in_item.value[31:0];
    if (in_item.is_wide) begin
      neg_in = in_item.is_signed && in_item.value[VALUE_W-1];
      mag_in = neg_in ? (VALUE_W'(0) - in_item.value) : in_item.value;
    end else begin
      neg_in = in_item.is_signed && low[31];
      mag_in = {32'd0, (neg_in ? (32'd0 - low) : low)};
    end
  end

  // digit cells: bits enter at cell 0, digits move toward the top cell
  assign bit_chain[0] = mag_r[VALUE_W-1];

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    logic [DIGIT_W-1:0] below;
    if (g == 0) begin : g_bot
      assign below = '0;
    end else begin : g_mid
      assign below = digits[g-1];
    end
    itda_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bit_chain[g]),
      .digit_in (below),
      .bit_out  (bit_chain[g+1]),
      .digit_q  (digits[g])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CONV;
      ST_CONV: if (cnt_r == '0) state_nxt = ST_TRIM;
      ST_TRIM: begin
        if (!(top_zero && left_r > LEFT_W'(1))) begin
          state_nxt = neg_r ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: if (can_load) state_nxt = ST_EMIT;
      ST_EMIT: if (can_load && left_r == LEFT_W'(1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // cell commands and handshake
  always_comb begin
    ctrl     = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        ctrl.clear = accept;
      end
      ST_CONV: ctrl.bit_shift   = 1'b1;
      ST_TRIM: ctrl.digit_shift = top_zero && (left_r > LEFT_W'(1));
      ST_SIGN: ctrl.digit_shift = 1'b0;
      ST_EMIT: ctrl.digit_shift = can_load;
      default: ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (can_load) begin
        out_valid_r <= (state_r == ST_SIGN) || (state_r == ST_EMIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mag_r <= mag_in;
          neg_r <= neg_in;
          cnt_r <= BITCNT_W'(VALUE_W - 1);
        end
      end
      ST_CONV: begin
        mag_r <= {mag_r[VALUE_W-2:0], 1'b0};
        cnt_r <= cnt_r - BITCNT_W'(1);
        if (cnt_r == '0) left_r <= LEFT_W'(NUM_DIGITS);
      end
      ST_TRIM: begin
        if (top_zero && left_r > LEFT_W'(1)) left_r <= left_r - LEFT_W'(1);
      end
      ST_SIGN: begin
        if (can_load) begin
          out_item_r.character <= ASCII_MINUS;
          out_item_r.last      <= 1'b0;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_item_r.character <= ASCII_ZERO + 8'(top_digit);
          out_item_r.last      <= (left_r == LEFT_W'(1));
          left_r               <= left_r - LEFT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- src/itda_checker.sv -----
// Port-level checks for the integer to decimal ASCII unit, bound to the top level.
`timescale 1ns / 1ps

module itda_checker
  import itda_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken while a conversion runs");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.character == ASCII_MINUS) ||
                  (out_item.character >= ASCII_ZERO &&
                   out_item.character <= ASCII_NINE))
    else $error("output character is neither a digit nor a minus sign");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> out_item.character != ASCII_MINUS)
    else $error("minus sign flagged as last character");

endmodule

bind integer_to_decimal_ascii_unit itda_checker u_itda_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ----- dv/testbench.sv -----
// Self-checking testbench for the integer to decimal ASCII unit.
`timescale 1ns / 1ps

module testbench;
  import itda_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 200;
  localparam int unsigned RANDOM_ITEMS   = 450;
  localparam int unsigned MAX_REPORTS    = 30;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_CHOPPY,
    RX_LONG
  } rx_mode_t;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pending_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  pending_t  pend_q[$];
  out_item_t text_q[$];

  int unsigned errors = 0;
  int unsigned numbers_taken = 0;
  int unsigned negatives_taken = 0;
  int unsigned chars_checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned stall_run = 0;
  logic [7:0]  mode_cycles = '0;
  rx_mode_t    rx_mode = RX_FREE;
  pending_t    next_up;
  out_item_t   want;

  integer_to_decimal_ascii_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("tb: mismatch on %s: got %0d, want %0d at %0t", what, got, exp_val, $realtime);
  endtask

  // Queues the characters of one number's decimal text.
  function automatic void predict_text(in_item_t it);
    logic [63:0] mag;
    logic [31:0] lo;
    logic        neg;
    logic [7:0]  digs[$];
    out_item_t   ch;
    if (it.is_wide) begin
      neg = it.is_signed && it.value[63];
      mag = neg ? 64'd0 - it.value : it.value;
    end else begin
      lo  = it.value[31:0];
      neg = it.is_signed && lo[31];
      mag = {32'd0, (neg ? 32'd0 - lo : lo)};
    end
    do begin
      digs.push_front(ASCII_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 0);
    if (neg) begin
      ch.character = ASCII_MINUS;
      ch.last      = 1'b0;
      text_q.push_back(ch);
      negatives_taken++;
    end
    foreach (digs[i]) begin
      ch.character = digs[i];
      ch.last      = (i == digs.size() - 1);
      text_q.push_back(ch);
    end
  endfunction

  function automatic void add_number(logic [63:0] v, logic sgn, logic wide, bit drain = 0);
    pending_t p;
    p.item.value     = v;
    p.item.is_signed = sgn;
    p.item.is_wide   = wide;
    p.drain_first    = drain;
    pend_q.push_back(p);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_item    <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(in_item);
        numbers_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pend_q.size() == 0 ||
                     (pend_q[0].drain_first && (out_valid || text_q.size() != 0))) begin
          // out_valid low means no character leaves at this edge, so the
          // queue size seen here does not depend on block ordering
          in_valid <= 1'b0;
        end else begin
          next_up  = pend_q.pop_front();
          in_item  <= next_up.item;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver stall pattern; the mode is picked anew whenever the 8-bit mode counter wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall   <= 1'b0;
      stall_run   <= 0;
      mode_cycles <= '0;
      rx_mode     <= RX_FREE;
    end else begin
      mode_cycles <= mode_cycles + 8'd1;
      if (mode_cycles == 8'hff)
        rx_mode <= rx_mode_t'($urandom_range(0, 2));
      if (stall_run != 0) begin
        stall_run <= stall_run - 1;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
          default: begin
            out_stall <= ~out_stall;
            stall_run <= $urandom_range(0, 12);
          end
        endcase
      end
    end
  end

  // Output checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      chars_checked++;
      if (text_q.size() == 0) begin
        report_mismatch("unexpected character", out_item.character, 0);
      end else begin
        want = text_q.pop_front();
        if (out_item.character !== want.character)
          report_mismatch("character", out_item.character, want.character);
        if (out_item.last !== want.last)
          report_mismatch("last", out_item.last, want.last);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [63:0] v;
    logic [63:0] p;
    logic        sgn;
    int unsigned kind;

    // Zero in every mode; narrow zero with high bits set
    add_number(64'd0, 0, 0);
    add_number(64'd0, 1, 0);
    add_number(64'd0, 0, 1);
    add_number(64'd0, 1, 1);
    add_number(64'hffff_ffff_0000_0000, 1, 0);
    // Wide extremes
    add_number(64'hffff_ffff_ffff_ffff, 0, 1);
    add_number(64'h8000_0000_0000_0000, 1, 1);
    add_number(64'hffff_ffff_ffff_ffff, 1, 1);
    add_number(64'h7fff_ffff_ffff_ffff, 1, 1);
    // Narrow extremes, upper half ignored
    add_number(64'hdead_beef_ffff_ffff, 0, 0);
    add_number(64'h1234_5678_8000_0000, 1, 0);
    add_number(64'hffff_ffff_ffff_ffff, 1, 0);
    add_number(64'hffff_ffff_7fff_ffff, 1, 0);
    // Digit count boundaries
    add_number(64'd9, 0, 1);
    add_number(64'd10, 0, 1);
    add_number(64'd99999999, 0, 1);
    add_number(64'd100000000, 0, 0);
    add_number(64'd9999999999999999999, 0, 1);
    add_number(64'd10000000000000000000, 0, 1);
    add_number(64'd0 - 64'd5, 1, 1);

    // First random item waits for the directed part to drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 3);
      sgn  = 1'($urandom_range(0, 1));
      case (kind)
        0: v = rand64();
        1: v = rand64() >> $urandom_range(0, 63);
        2: begin
          p = 64'd1;
          repeat ($urandom_range(0, 19)) p = p * 64'd10;
          v = p + 64'($urandom_range(0, 2)) - 64'd1;
          if (sgn && $urandom_range(0, 1) == 1) v = 64'd0 - v;
        end
        default: begin
          v = ($urandom_range(0, 1) == 1) ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
          v = v + 64'($urandom_range(0, 4)) - 64'd2;
          if ($urandom_range(0, 1) == 1) v = v ^ {$urandom, 32'd0};
        end
      endcase
      add_number(v, sgn, 1'($urandom_range(0, 1)), n == 0 || $urandom_range(0, 39) == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() != 0 || in_valid) @(negedge clk);
    while (text_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run: %0d numbers converted (%0d negative), %0d characters checked",
             numbers_taken, negatives_taken, chars_checked);
    $display("run: 32/64-bit, signed/unsigned, extremes, zero, digit boundaries, idles");
    if (errors == 0 && text_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- integer_to_decimal_ascii_unit.f -----
src/itda_pkg.sv
src/itda_cell.sv
src/integer_to_decimal_ascii_unit.sv
src/itda_checker.sv
dv/testbench.sv
